// File: rtl/core/xfr_pkg.sv
// Types, constants and exponential tables shared by the exponential crossfade ramp.
package xfr_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int ALPHA_W         = FRAC_BITS + 1;
	localparam int TAU_W           = 24;
	localparam int EPS_W           = 16;
	localparam int DELTA_W         = 21;
	localparam int TGT_W           = 18;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 24;

	localparam int EXP_TABLE_DEPTH = 256;
	localparam int IDX_BITS        = $clog2(EXP_TABLE_DEPTH);
	localparam int Q30_FRAC        = 30;
	localparam int Q30_W           = Q30_FRAC + 1;
	localparam int INT_BITS        = 4;
	localparam int INT_STEPS       = 1 << INT_BITS;
	localparam int X_BITS          = Q30_FRAC + INT_BITS;
	localparam int CNT_W           = $clog2(X_BITS);
	localparam int MUL_W           = Q30_W;
	localparam int PROD_W          = 2 * MUL_W;
	localparam int TERMS           = 24;

	localparam logic OP_ADVANCE = 1'b0;
	localparam logic OP_TOGGLE  = 1'b1;

	localparam logic [ALPHA_W-1:0] UNIT      = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [TAU_W-1:0]   TAU_RESET = 24'd320000;
	localparam logic [EPS_W-1:0]   EPS_RESET = 16'd328;
	localparam longint             Q30_ONE   = 64'sd1 <<< Q30_FRAC;
	localparam longint             E_RND     = 64'sd1 <<< (Q30_FRAC - FRAC_BITS - 1);
	localparam longint             STEP_RND  = 64'sd1 <<< (FRAC_BITS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAU_US   = 1'b0,
		REG_SNAP_EPS = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_LO,
		ST_HI,
		ST_MUL_INTERP,
		ST_EF,
		ST_MUL_INT,
		ST_K,
		ST_MUL_STEP,
		ST_UPD,
		ST_SNAP,
		ST_DONE
	} fsm_state_t;

	typedef logic [EXP_TABLE_DEPTH:0][Q30_W-1:0] exp_frac_tab_t;
	typedef logic [INT_STEPS-1:0][Q30_W-1:0]     exp_int_tab_t;

	// truncating quotient of a non-negative numerator by a small positive divisor
	function automatic longint udiv_small(input longint num, input int den);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((num >>> b) & 64'sd1);
			q = q <<< 1;
			if (r >= longint'(den)) begin
				r = r - longint'(den);
				q = q | 64'sd1;
			end
		end
		return q;
	endfunction

	// exp(-f), f in Q30 within 0..1, truncated Taylor series
	function automatic longint exp_neg_q30(input longint f);
		longint term;
		longint sum;
		term = Q30_ONE;
		sum  = Q30_ONE;
		for (int n = 1; n <= TERMS; n++) begin
			term = udiv_small((term * f) >>> Q30_FRAC, n);
			if (n[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	function automatic exp_frac_tab_t build_frac_tab();
		exp_frac_tab_t tab;
		for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
			tab[i] = Q30_W'(exp_neg_q30((longint'(i) <<< Q30_FRAC) >>> IDX_BITS));
		end
		return tab;
	endfunction

	localparam exp_frac_tab_t EXP_FRAC_TAB = build_frac_tab();

	function automatic exp_int_tab_t build_int_tab();
		exp_int_tab_t tab;
		longint       acc;
		acc    = Q30_ONE;
		tab[0] = Q30_W'(acc);
		for (int i = 1; i < INT_STEPS; i++) begin
			acc    = (acc * longint'(EXP_FRAC_TAB[EXP_TABLE_DEPTH])) >>> Q30_FRAC;
			tab[i] = Q30_W'(acc);
		end
		return tab;
	endfunction

	localparam exp_int_tab_t EXP_INT_TAB = build_int_tab();

endpackage

// File: rtl/core/exponential_crossfade_ramp.sv
// Exponential crossfade ramp: one-pole blend update with a serial divider and one shared multiplier.
// Advance item: 34 divider steps (one quotient bit a cycle), then nine sequencer steps around
// the shared 31x31 multiplier, then one load step.
// Ratio of 16 or more skips the divider. Toggle or nonpositive delta goes straight to the load step.
// One item at a time: the next is taken the cycle after its result is stored.
// Reset: tau_us 320000, snap_eps 328, blend factor one, target flag set, no result pending.
module exponential_crossfade_ramp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                func,
	input  logic signed [xfr_pkg::DELTA_W-1:0]  elapsed_us,
	input  logic signed [xfr_pkg::TGT_W-1:0]    goal_level,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [xfr_pkg::ALPHA_W-1:0]         alpha,
	output logic                                solid,
	output logic                                target_high,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [xfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [xfr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int ALPHA_W = xfr_pkg::ALPHA_W;
	localparam int TAU_W   = xfr_pkg::TAU_W;
	localparam int MUL_W   = xfr_pkg::MUL_W;
	localparam int PROD_W  = xfr_pkg::PROD_W;
	localparam int Q30F    = xfr_pkg::Q30_FRAC;
	localparam int IDXB    = xfr_pkg::IDX_BITS;
	localparam int XB      = xfr_pkg::X_BITS;
	localparam int INTB    = xfr_pkg::INT_BITS;
	localparam int FB      = xfr_pkg::FRAC_BITS;
	localparam int DMAG_W  = xfr_pkg::DELTA_W - 1;
	localparam int CMP_W   = TAU_W + INTB;
	localparam int STEP_W  = 2 * ALPHA_W;

	xfr_pkg::fsm_state_t state_q, state_nxt;

	logic [TAU_W-1:0]            tau_q;
	logic [xfr_pkg::EPS_W-1:0]   eps_q;
	logic [ALPHA_W-1:0]          blend_q;
	logic                        stored_target_q;
	logic                        result_valid_q;

	logic [TAU_W-1:0]            t_q;
	logic [TAU_W-1:0]            rem_q;
	logic [XB-1:0]               quo_q;
	logic [xfr_pkg::CNT_W-1:0]   cnt_q;
	logic [xfr_pkg::Q30_W-1:0]   lo_q;
	logic [MUL_W-1:0]            span_q;
	logic [xfr_pkg::Q30_W-1:0]   ef_q;
	logic [ALPHA_W-1:0]          k_q;
	logic [PROD_W-1:0]           prod_q;
	logic [ALPHA_W-1:0]          absdiff_q;
	logic                        neg_q;
	logic [ALPHA_W-1:0]          tgt_q;
	logic [ALPHA_W-1:0]          alpha_q;
	logic                        solid_q;
	logic                        target_high_q;

	logic                        item_acc;
	logic                        load_res;
	logic [TAU_W-1:0]            t_sel;
	logic                        delta_pos;
	logic                        delta_big;
	logic [ALPHA_W-1:0]          tgt_clamp;
	logic [TAU_W+1:0]            trial;
	logic [IDXB:0]               tab_idx;
	logic [xfr_pkg::Q30_W-1:0]   tab_val;
	logic [MUL_W-1:0]            mul_a;
	logic [MUL_W-1:0]            mul_b;
	logic                        mul_en;
	logic [PROD_W-Q30F:0]        e_rnd;
	logic [ALPHA_W-1:0]          e_clamp;
	logic [STEP_W:0]             step_rnd;
	logic [ALPHA_W-1:0]          step;
	logic [ALPHA_W-1:0]          eps_hi;

	// accept-time decode
	always_comb begin
		t_sel     = (tau_q == '0) ? TAU_W'(1) : tau_q;
		delta_pos = !elapsed_us[xfr_pkg::DELTA_W-1] && (elapsed_us != '0);
		delta_big = {{(CMP_W-DMAG_W){1'b0}}, elapsed_us[DMAG_W-1:0]} >= {t_sel, {INTB{1'b0}}};
		priority if (goal_level[xfr_pkg::TGT_W-1]) begin
			tgt_clamp = '0;
		end else if (goal_level > $signed({1'b0, xfr_pkg::UNIT})) begin
			tgt_clamp = xfr_pkg::UNIT;
		end else begin
			tgt_clamp = goal_level[ALPHA_W-1:0];
		end
	end

	assign trial   = {1'b0, rem_q, quo_q[XB-1]} - {2'b00, t_q};
	assign tab_val = xfr_pkg::EXP_FRAC_TAB[tab_idx];
	assign e_rnd   = {1'b0, prod_q[PROD_W-1:Q30F]} + (PROD_W-Q30F+1)'(xfr_pkg::E_RND);
	assign e_clamp = (e_rnd[PROD_W-Q30F:Q30F-FB] > {2'b00, xfr_pkg::UNIT}) ?
		xfr_pkg::UNIT : e_rnd[Q30F-FB+ALPHA_W-1:Q30F-FB];
	assign step_rnd = {1'b0, prod_q[STEP_W-1:0]} + (STEP_W+1)'(xfr_pkg::STEP_RND);
	assign step     = step_rnd[FB+ALPHA_W-1:FB];
	assign eps_hi   = xfr_pkg::UNIT - {1'b0, eps_q};

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			xfr_pkg::ST_IDLE: begin
				if (item_valid) begin
					priority if ((func == xfr_pkg::OP_TOGGLE) || !delta_pos) begin
						state_nxt = xfr_pkg::ST_DONE;
					end else if (delta_big) begin
						state_nxt = xfr_pkg::ST_MUL_STEP;
					end else begin
						state_nxt = xfr_pkg::ST_DIV;
					end
				end
			end
			xfr_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_nxt = xfr_pkg::ST_LO;
				end
			end
			xfr_pkg::ST_LO:         state_nxt = xfr_pkg::ST_HI;
			xfr_pkg::ST_HI:         state_nxt = xfr_pkg::ST_MUL_INTERP;
			xfr_pkg::ST_MUL_INTERP: state_nxt = xfr_pkg::ST_EF;
			xfr_pkg::ST_EF:         state_nxt = xfr_pkg::ST_MUL_INT;
			xfr_pkg::ST_MUL_INT:    state_nxt = xfr_pkg::ST_K;
			xfr_pkg::ST_K:          state_nxt = xfr_pkg::ST_MUL_STEP;
			xfr_pkg::ST_MUL_STEP:   state_nxt = xfr_pkg::ST_UPD;
			xfr_pkg::ST_UPD:        state_nxt = xfr_pkg::ST_SNAP;
			xfr_pkg::ST_SNAP:       state_nxt = xfr_pkg::ST_DONE;
			xfr_pkg::ST_DONE: begin
				if (load_res) begin
					state_nxt = xfr_pkg::ST_IDLE;
				end
			end
			default:                state_nxt = xfr_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, table index, multiplier operands
	always_comb begin
		item_stall = (state_q != xfr_pkg::ST_IDLE);
		item_acc   = item_valid && (state_q == xfr_pkg::ST_IDLE);
		load_res   = (state_q == xfr_pkg::ST_DONE) && (!result_valid_q || !result_stall);
		tab_idx    = {1'b0, quo_q[Q30F-1 -: IDXB]};
		mul_a      = '0;
		mul_b      = '0;
		mul_en     = 1'b0;
		unique case (state_q)
			xfr_pkg::ST_HI: begin
				tab_idx = {1'b0, quo_q[Q30F-1 -: IDXB]} + (IDXB+1)'(1);
			end
			xfr_pkg::ST_MUL_INTERP: begin
				mul_en = 1'b1;
				mul_a  = span_q;
				mul_b  = {{(MUL_W-Q30F){1'b0}}, quo_q[Q30F-IDXB-1:0], {IDXB{1'b0}}};
			end
			xfr_pkg::ST_MUL_INT: begin
				mul_en = 1'b1;
				mul_a  = ef_q;
				mul_b  = xfr_pkg::EXP_INT_TAB[quo_q[XB-1:Q30F]];
			end
			xfr_pkg::ST_MUL_STEP: begin
				mul_en = 1'b1;
				mul_a  = {{(MUL_W-ALPHA_W){1'b0}}, absdiff_q};
				mul_b  = {{(MUL_W-ALPHA_W){1'b0}}, k_q};
			end
			default: begin
			end
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= xfr_pkg::ST_IDLE;
			tau_q           <= xfr_pkg::TAU_RESET;
			eps_q           <= xfr_pkg::EPS_RESET;
			blend_q         <= xfr_pkg::UNIT;
			stored_target_q <= 1'b1;
			result_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				unique case (xfr_pkg::cfg_reg_t'(cfg_index))
					xfr_pkg::REG_TAU_US:   tau_q <= cfg_data[TAU_W-1:0];
					xfr_pkg::REG_SNAP_EPS: eps_q <= cfg_data[xfr_pkg::EPS_W-1:0];
					default: begin
					end
				endcase
			end
			if (item_acc && (func == xfr_pkg::OP_TOGGLE)) begin
				stored_target_q <= !stored_target_q;
			end
			if (state_q == xfr_pkg::ST_UPD) begin
				blend_q <= neg_q ? (blend_q - step) : (blend_q + step);
			end
			if (state_q == xfr_pkg::ST_SNAP) begin
				priority if ((tgt_q == '0) && (blend_q < {1'b0, eps_q})) begin
					blend_q <= '0;
				end else if ((tgt_q == xfr_pkg::UNIT) && (blend_q > eps_hi)) begin
					blend_q <= xfr_pkg::UNIT;
				end
			end
			priority if (load_res) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (item_acc) begin
			t_q   <= t_sel;
			rem_q <= {{(TAU_W-DMAG_W+INTB){1'b0}}, elapsed_us[DMAG_W-1:INTB]};
			quo_q <= {elapsed_us[INTB-1:0], {Q30F{1'b0}}};
			cnt_q <= xfr_pkg::CNT_W'(XB - 1);
			k_q   <= xfr_pkg::UNIT;
			tgt_q <= tgt_clamp;
			if (tgt_clamp >= blend_q) begin
				absdiff_q <= tgt_clamp - blend_q;
				neg_q     <= 1'b0;
			end else begin
				absdiff_q <= blend_q - tgt_clamp;
				neg_q     <= 1'b1;
			end
		end
		if (state_q == xfr_pkg::ST_DIV) begin
			cnt_q <= cnt_q - xfr_pkg::CNT_W'(1);
			if (!trial[TAU_W+1]) begin
				rem_q <= trial[TAU_W-1:0];
				quo_q <= {quo_q[XB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[TAU_W-2:0], quo_q[XB-1]};
				quo_q <= {quo_q[XB-2:0], 1'b0};
			end
		end
		if (state_q == xfr_pkg::ST_LO) begin
			lo_q <= tab_val;
		end
		if (state_q == xfr_pkg::ST_HI) begin
			span_q <= lo_q - tab_val;
		end
		if (state_q == xfr_pkg::ST_EF) begin
			ef_q <= lo_q - prod_q[Q30F+xfr_pkg::Q30_W-1:Q30F];
		end
		if (state_q == xfr_pkg::ST_K) begin
			k_q <= xfr_pkg::UNIT - e_clamp;
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (load_res) begin
			alpha_q       <= blend_q;
			solid_q       <= (blend_q <= {1'b0, eps_q}) || (blend_q >= eps_hi);
			target_high_q <= stored_target_q;
		end
	end

	assign result_valid = result_valid_q;
	assign alpha        = alpha_q;
	assign solid        = solid_q;
	assign target_high  = target_high_q;
	assign cfg_ready    = 1'b1;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> state_q != xfr_pkg::ST_IDLE)
		else $error("sequencer idle right after an accepted request");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == xfr_pkg::ST_DIV |-> rem_q < t_q)
		else $error("divider remainder not below divisor");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == xfr_pkg::ST_MUL_STEP |-> k_q <= xfr_pkg::UNIT)
		else $error("closing fraction above one");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == xfr_pkg::ST_DONE && !result_valid_q |=> result_valid_q
			&& state_q == xfr_pkg::ST_IDLE && alpha_q <= xfr_pkg::UNIT)
		else $error("finished result not loaded");
`endif

endmodule
